>>> rtl/order_book_depth_imbalance_core_macros.svh
// Assertion macros for the depth imbalance core
`ifndef ORDER_BOOK_DEPTH_IMBALANCE_CORE_MACROS_SVH
`define ORDER_BOOK_DEPTH_IMBALANCE_CORE_MACROS_SVH

// same-cycle implication
`define OBDI_AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obdi assertion failed");

// next-cycle implication
`define OBDI_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obdi assertion failed");

`endif

>>> rtl/obdi_pkg.sv
// Shared types and constants for the depth imbalance core
`default_nettype none
package obdi_pkg;

    localparam int PW  = 32;          // price / volume width
    localparam int DW  = 36;          // depth width
    localparam int MW  = 33;          // mid x2 and spread width
    localparam int D2W = 34;          // doubled distance width
    localparam int NW  = 81;          // weight numerator / quotient width
    localparam int WW  = 86;          // weight accumulator width
    localparam int QW  = 16;          // Q1.15 result width
    localparam int IMB_STEPS = 15;

    localparam logic [1:0] REG_TICK         = 2'd0;
    localparam logic [1:0] REG_DEPTH_LEVELS = 2'd1;

    typedef struct packed {
        logic load_item;
        logic mid_upd;
        logic rd;
        logic to_ask;
        logic mul;
        logic div_init;
        logic div_step;
        logic acc;
        logic skip;
        logic imb_init;
        logic imb_step;
        logic imb_sel;
        logic save_v;
        logic save_w;
        logic publish;
    } obdi_cmd_t;

    typedef struct packed {
        logic cur_valid;
        logic on_ask;
        logic w_pos;
        logic div_last;
        logic imb_done;
        logic out_free;
    } obdi_sts_t;

    typedef enum logic [11:0] {
        ST_LOAD = 12'b0000_0000_0001,
        ST_MID  = 12'b0000_0000_0010,
        ST_SEL  = 12'b0000_0000_0100,
        ST_MUL  = 12'b0000_0000_1000,
        ST_CHK  = 12'b0000_0001_0000,
        ST_DIV  = 12'b0000_0010_0000,
        ST_ACC  = 12'b0000_0100_0000,
        ST_VI   = 12'b0000_1000_0000,
        ST_VS   = 12'b0001_0000_0000,
        ST_WI   = 12'b0010_0000_0000,
        ST_WS   = 12'b0100_0000_0000,
        ST_FIN  = 12'b1000_0000_0000
    } obdi_state_t;

endpackage
`default_nettype wire

>>> rtl/order_book_depth_imbalance_core.sv
// Top level of the order book depth imbalance core
//
// Level words arrive on the in_ channel (valid/stall), one bid and one ask level
// per word, last_level marking the end of a snapshot. Level words are taken one
// per cycle while in_stall is low. The closing word starts the end-of-snapshot
// work and in_stall stays high until the result has been moved into the output
// register. That work is the mid update, a walk over each side's kept levels with
// a bit-serial weight division for each one at a positive distance from mid, the
// side change and walk end, the two imbalance divisions and the publish; the
// weight divider dominates it. The result word sits in the out_ register
// (valid/stall); while it is stalled the next snapshot may load, and its result
// waits in the datapath until the register frees. Configuration (cfg_valid/
// cfg_ready, cfg_ready always high) must be written by the user only when the
// block is idle; the block does not enforce this. Reset clears counters, held
// mid, spread and time, and sets the tick size to 1 and depth_levels to 5.
`default_nettype none
`include "order_book_depth_imbalance_core_macros.svh"
module order_book_depth_imbalance_core
    import obdi_pkg::*;
#(
    parameter int MAX_LEVELS = 10
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [31:0]          bid_price,
    input  wire logic [31:0]          bid_volume,
    input  wire logic [31:0]          ask_price,
    input  wire logic [31:0]          ask_volume,
    input  wire logic [31:0]          snap_time,
    input  wire logic                 last_level,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [31:0]               time_out,
    output logic [32:0]               mid_price_x2,
    output logic signed [32:0]        spread_out,
    output logic [35:0]               bid_vol_sum,
    output logic [35:0]               ask_vol_sum,
    output logic signed [15:0]        volume_imbalance,
    output logic signed [15:0]        weighted_imbalance,
    output logic [3:0]                bid_levels,
    output logic [3:0]                ask_levels
);

    obdi_cmd_t cmd;
    obdi_sts_t sts;

    assign cfg_ready = 1'b1;

    obdi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_level),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    obdi_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .bid_price          (bid_price),
        .bid_volume         (bid_volume),
        .ask_price          (ask_price),
        .ask_volume         (ask_volume),
        .snap_time          (snap_time),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .time_out           (time_out),
        .mid_price_x2       (mid_price_x2),
        .spread_out         (spread_out),
        .bid_vol_sum        (bid_vol_sum),
        .ask_vol_sum        (ask_vol_sum),
        .volume_imbalance   (volume_imbalance),
        .weighted_imbalance (weighted_imbalance),
        .bid_levels         (bid_levels),
        .ask_levels         (ask_levels)
    );

    `OBDI_AST_NOW(a_publish_free, cmd.publish, sts.out_free)
    `OBDI_AST_NXT(a_publish_shows, cmd.publish, out_valid)
    `OBDI_AST_NXT(a_last_busy, in_valid && !in_stall && last_level, in_stall)

endmodule
`default_nettype wire

>>> rtl/obdi_ctrl.sv
// Sequencer for snapshot loading and the end-of-snapshot arithmetic
`default_nettype none
module obdi_ctrl
    import obdi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_last,
    input  wire obdi_sts_t sts,
    output logic           in_stall,
    output obdi_cmd_t      cmd
);

    obdi_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_LOAD);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load_item = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_MID;
                end
            end
            ST_MID:
            begin
                cmd.mid_upd = 1'b1;
                state_next  = ST_SEL;
            end
            ST_SEL:
            begin
                if (sts.cur_valid)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_MUL;
                end
                else if (!sts.on_ask)
                begin
                    cmd.to_ask = 1'b1;
                end
                else
                begin
                    state_next = ST_VI;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.w_pos)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.skip   = 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_SEL;
            end
            ST_VI:
            begin
                cmd.imb_init = 1'b1;
                state_next   = ST_VS;
            end
            ST_VS:
            begin
                if (sts.imb_done)
                begin
                    cmd.save_v = 1'b1;
                    state_next = ST_WI;
                end
                else
                begin
                    cmd.imb_step = 1'b1;
                end
            end
            ST_WI:
            begin
                cmd.imb_init = 1'b1;
                cmd.imb_sel  = 1'b1;
                state_next   = ST_WS;
            end
            ST_WS:
            begin
                if (sts.imb_done)
                begin
                    cmd.save_w = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.imb_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/obdi_dp.sv
// Datapath: level stores, weight divider, imbalance divider, result registers
`default_nettype none
module obdi_dp
    import obdi_pkg::*;
#(
    parameter int MAX_LEVELS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire obdi_cmd_t             cmd,
    output obdi_sts_t                  sts,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic [PW-1:0]         bid_price,
    input  wire logic [PW-1:0]         bid_volume,
    input  wire logic [PW-1:0]         ask_price,
    input  wire logic [PW-1:0]         ask_volume,
    input  wire logic [31:0]           snap_time,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [31:0]                time_out,
    output logic [MW-1:0]              mid_price_x2,
    output logic signed [MW-1:0]       spread_out,
    output logic [DW-1:0]              bid_vol_sum,
    output logic [DW-1:0]              ask_vol_sum,
    output logic signed [QW-1:0]       volume_imbalance,
    output logic signed [QW-1:0]       weighted_imbalance,
    output logic [3:0]                 bid_levels,
    output logic [3:0]                 ask_levels
);

    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    // configuration
    logic [31:0] tick_reg;
    logic [3:0]  depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= 32'd1;
            depth_reg <= 4'd5;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TICK)
            begin
                tick_reg <= cfg_data;
            end
            else if (cfg_index == REG_DEPTH_LEVELS)
            begin
                depth_reg <= cfg_data[3:0];
            end
        end
    end

    // level stores
    logic [PW-1:0] bp_mem [MAX_LEVELS];
    logic [PW-1:0] bv_mem [MAX_LEVELS];
    logic [PW-1:0] ap_mem [MAX_LEVELS];
    logic [PW-1:0] av_mem [MAX_LEVELS];

    logic [CW-1:0] bid_cnt_reg, ask_cnt_reg, item_cnt_reg;
    logic [CW-1:0] depth_eff;
    logic          in_depth, bid_keep, ask_keep;
    logic [PW-1:0] best_bid_reg, best_ask_reg;
    logic [DW-1:0] bd_reg, ad_reg;
    logic [31:0]   held_time_reg;
    logic [MW-1:0] held_mid_reg, held_spread_reg;

    always_comb
    begin
        if ({2'b00, depth_reg} > 6'(MAX_LEVELS))
        begin
            depth_eff = CW'(MAX_LEVELS);
        end
        else
        begin
            depth_eff = CW'(depth_reg);
        end
    end

    assign in_depth = (item_cnt_reg < depth_eff);
    assign bid_keep = cmd.load_item && in_depth && (bid_price != '0) && (bid_volume != '0);
    assign ask_keep = cmd.load_item && in_depth && (ask_price != '0) && (ask_volume != '0);

    always_ff @(posedge clk)
    begin
        if (bid_keep)
        begin
            bp_mem[bid_cnt_reg[AW-1:0]] <= bid_price;
            bv_mem[bid_cnt_reg[AW-1:0]] <= bid_volume;
        end
        if (ask_keep)
        begin
            ap_mem[ask_cnt_reg[AW-1:0]] <= ask_price;
            av_mem[ask_cnt_reg[AW-1:0]] <= ask_volume;
        end
        if (bid_keep && bid_cnt_reg == '0)
        begin
            best_bid_reg <= bid_price;
        end
        if (ask_keep && ask_cnt_reg == '0)
        begin
            best_ask_reg <= ask_price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_cnt_reg     <= '0;
            ask_cnt_reg     <= '0;
            item_cnt_reg    <= '0;
            bd_reg          <= '0;
            ad_reg          <= '0;
            held_time_reg   <= '0;
            held_mid_reg    <= '0;
            held_spread_reg <= '0;
        end
        else if (cmd.publish)
        begin
            bid_cnt_reg  <= '0;
            ask_cnt_reg  <= '0;
            item_cnt_reg <= '0;
            bd_reg       <= '0;
            ad_reg       <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                held_time_reg <= snap_time;
                if (item_cnt_reg < CW'(MAX_LEVELS))
                begin
                    item_cnt_reg <= item_cnt_reg + 1'b1;
                end
            end
            if (bid_keep)
            begin
                bid_cnt_reg <= bid_cnt_reg + 1'b1;
                bd_reg      <= bd_reg + DW'(bid_volume);
            end
            if (ask_keep)
            begin
                ask_cnt_reg <= ask_cnt_reg + 1'b1;
                ad_reg      <= ad_reg + DW'(ask_volume);
            end
            if (cmd.mid_upd && bid_cnt_reg != '0 && ask_cnt_reg != '0)
            begin
                held_mid_reg    <= {1'b0, best_bid_reg} + {1'b0, best_ask_reg};
                held_spread_reg <= {1'b0, best_ask_reg} - {1'b0, best_bid_reg};
            end
        end
    end

    // level walk
    logic          side_reg;
    logic [CW-1:0] idx_reg;
    logic [PW-1:0] rd_bp_reg, rd_bv_reg, rd_ap_reg, rd_av_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (cmd.mid_upd)
        begin
            side_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (cmd.to_ask)
        begin
            side_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (cmd.acc || cmd.skip)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_bp_reg <= bp_mem[idx_reg[AW-1:0]];
            rd_bv_reg <= bv_mem[idx_reg[AW-1:0]];
            rd_ap_reg <= ap_mem[idx_reg[AW-1:0]];
            rd_av_reg <= av_mem[idx_reg[AW-1:0]];
        end
    end

    // product and distance
    logic [63:0]         prod_reg;
    logic [D2W-1:0]      d2_reg;
    logic                wpos_reg;
    logic signed [D2W:0] d2_diff;
    logic [PW-1:0]       sel_p, sel_v;

    assign sel_p = side_reg ? rd_ap_reg : rd_bp_reg;
    assign sel_v = side_reg ? rd_av_reg : rd_bv_reg;

    always_comb
    begin
        if (side_reg)
        begin
            d2_diff = $signed({2'b00, sel_p, 1'b0}) - $signed({2'b00, held_mid_reg});
        end
        else
        begin
            d2_diff = $signed({2'b00, held_mid_reg}) - $signed({2'b00, sel_p, 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= 64'(sel_v) * 64'(tick_reg);
            d2_reg   <= d2_diff[D2W-1:0];
            wpos_reg <= (d2_diff > 0);
        end
    end

    // weight divider, one quotient bit a cycle
    logic [NW-1:0]  num_reg, q_reg;
    logic [D2W-1:0] rem_reg;
    logic [6:0]     dcnt_reg;
    logic [D2W:0]   rs;
    logic           rs_ge;

    assign rs    = {rem_reg, num_reg[NW-1]};
    assign rs_ge = (rs >= {1'b0, d2_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            num_reg  <= {prod_reg, 17'd0};
            q_reg    <= '0;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            q_reg    <= {q_reg[NW-2:0], rs_ge};
            rem_reg  <= rs_ge ? D2W'(rs - {1'b0, d2_reg}) : rs[D2W-1:0];
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    logic [WW-1:0] wb_reg, wa_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mid_upd)
        begin
            wb_reg <= '0;
            wa_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (side_reg)
            begin
                wa_reg <= wa_reg + WW'(q_reg);
            end
            else
            begin
                wb_reg <= wb_reg + WW'(q_reg);
            end
        end
    end

    // imbalance divider, shared by both imbalances
    logic [WW-1:0] ia, ib;
    logic          ineg;
    logic [WW:0]   idiff0, isum0;
    logic [WW+1:0] idiff_reg, ids;
    logic [WW:0]   isum_reg;
    logic          neg_reg;
    logic [QW-1:0] iq_reg;
    logic [3:0]    icnt_reg;
    logic          ids_ge;
    logic [QW-1:0] imb_res;

    assign ia     = cmd.imb_sel ? wb_reg : WW'(bd_reg);
    assign ib     = cmd.imb_sel ? wa_reg : WW'(ad_reg);
    assign ineg   = (ia < ib);
    assign idiff0 = ineg ? ({1'b0, ib} - {1'b0, ia}) : ({1'b0, ia} - {1'b0, ib});
    assign isum0  = {1'b0, ia} + {1'b0, ib};
    assign ids    = {idiff_reg[WW:0], 1'b0};
    assign ids_ge = (ids >= {1'b0, isum_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.imb_init)
        begin
            neg_reg   <= ineg;
            idiff_reg <= {1'b0, idiff0};
            isum_reg  <= isum0;
            if (isum0 == '0)
            begin
                iq_reg   <= '0;
                icnt_reg <= 4'(IMB_STEPS);
            end
            else if (idiff0 >= isum0)
            begin
                iq_reg   <= 16'h8000;
                icnt_reg <= 4'(IMB_STEPS);
            end
            else
            begin
                iq_reg   <= '0;
                icnt_reg <= '0;
            end
        end
        else if (cmd.imb_step)
        begin
            idiff_reg <= ids_ge ? (ids - {1'b0, isum_reg}) : ids;
            iq_reg    <= {iq_reg[QW-2:0], ids_ge};
            icnt_reg  <= icnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            imb_res = QW'(17'h10000 - {1'b0, iq_reg});
        end
        else if (iq_reg > 16'd32767)
        begin
            imb_res = 16'd32767;
        end
        else
        begin
            imb_res = iq_reg;
        end
    end

    logic [QW-1:0] vimb_reg, wimb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.save_v)
        begin
            vimb_reg <= imb_res;
        end
        if (cmd.save_w)
        begin
            wimb_reg <= imb_res;
        end
    end

    // result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            time_out           <= held_time_reg;
            mid_price_x2       <= held_mid_reg;
            spread_out         <= $signed(held_spread_reg);
            bid_vol_sum        <= bd_reg;
            ask_vol_sum        <= ad_reg;
            volume_imbalance   <= $signed(vimb_reg);
            weighted_imbalance <= $signed(wimb_reg);
            bid_levels         <= 4'(bid_cnt_reg);
            ask_levels         <= 4'(ask_cnt_reg);
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        sts.cur_valid = side_reg ? (idx_reg < ask_cnt_reg) : (idx_reg < bid_cnt_reg);
        sts.on_ask    = side_reg;
        sts.w_pos     = wpos_reg;
        sts.div_last  = (dcnt_reg == 7'(NW - 1));
        sts.imb_done  = (icnt_reg == 4'(IMB_STEPS));
        sts.out_free  = !out_valid_reg || !out_stall;
    end

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for order_book_depth_imbalance_core: randomised snapshots, own predictor
`default_nettype none
module tb_top;
    import obdi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  BOOK_LEVELS = 10;
    localparam int  DRAIN_CYCLES = 2000;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [31:0] bid_price;
        logic [31:0] bid_volume;
        logic [31:0] ask_price;
        logic [31:0] ask_volume;
        logic [31:0] snap_time;
        logic        last_level;
    } level_word_t;

    typedef struct packed {
        logic [31:0]        time_out;
        logic [32:0]        mid_price_x2;
        logic signed [32:0] spread_out;
        logic [35:0]        bid_vol_sum;
        logic [35:0]        ask_vol_sum;
        logic signed [15:0] volume_imbalance;
        logic signed [15:0] weighted_imbalance;
        logic [3:0]         bid_levels;
        logic [3:0]         ask_levels;
    } book_stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_TICK;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [31:0] bid_price = '0, bid_volume = '0, ask_price = '0, ask_volume = '0;
    logic [31:0] snap_time = '0;
    logic last_level = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    book_stats_t got;

    order_book_depth_imbalance_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .bid_price(bid_price), .bid_volume(bid_volume), .ask_price(ask_price),
        .ask_volume(ask_volume), .snap_time(snap_time), .last_level(last_level),
        .out_valid(out_valid), .out_stall(out_stall),
        .time_out(got.time_out), .mid_price_x2(got.mid_price_x2),
        .spread_out(got.spread_out), .bid_vol_sum(got.bid_vol_sum),
        .ask_vol_sum(got.ask_vol_sum), .volume_imbalance(got.volume_imbalance),
        .weighted_imbalance(got.weighted_imbalance), .bid_levels(got.bid_levels),
        .ask_levels(got.ask_levels)
    );

    initial forever #4 clk = ~clk;

    // ---------------- predictor state ----------------
    logic [31:0] tick_reg = 32'd1;
    logic [3:0]  depth_reg = 4'd5;
    logic [31:0] bid_px [BOOK_LEVELS];
    logic [31:0] bid_vol [BOOK_LEVELS];
    logic [31:0] ask_px [BOOK_LEVELS];
    logic [31:0] ask_vol [BOOK_LEVELS];
    int          n_bid = 0, n_ask = 0, n_items = 0;
    logic [32:0] mid_x2_hold = '0;
    logic [32:0] spread_hold = '0;

    level_word_t level_q[$];
    book_stats_t stats_q[$];
    int send_idle = 0, recv_idle = 0;
    int mismatches = 0;
    bit failed = 0;

    // floor(vol * tick * 2^17 / d2)
    function automatic logic [85:0] inv_dist_weight(logic [31:0] vol, logic [33:0] d2);
        logic [80:0] num;
        num = {17'd0, 64'(vol) * 64'(tick_reg)} << 17;
        return 86'(num / 81'(d2));
    endfunction

    // signed Q1.15 of (a-b)/(a+b), truncated toward zero
    function automatic logic [15:0] q15_imbalance(logic [85:0] a, logic [85:0] b);
        logic [86:0]  sum;
        logic [86:0]  diff;
        logic [103:0] q;
        bit neg;
        neg = a < b;
        diff = neg ? 87'(b) - 87'(a) : 87'(a) - 87'(b);
        sum = 87'(a) + 87'(b);
        if (sum == 0)
            return 16'd0;
        q = diff >= sum ? 104'd32768 : (104'(diff) << 15) / 104'(sum);
        if (!neg)
            return q > 32767 ? 16'd32767 : 16'(q);
        return 16'(17'h10000 - 17'(q));
    endfunction

    function automatic void book_update(level_word_t w);
        int depth;
        logic [35:0] bd, ad;
        logic [85:0] wb, wa;
        logic [33:0] p2;
        book_stats_t r;
        depth = depth_reg > BOOK_LEVELS ? BOOK_LEVELS : depth_reg;
        bd = '0; ad = '0; wb = '0; wa = '0;
        if (n_items < depth) begin
            if (w.bid_price != 0 && w.bid_volume != 0 && n_bid < BOOK_LEVELS) begin
                bid_px[n_bid] = w.bid_price;
                bid_vol[n_bid] = w.bid_volume;
                n_bid++;
            end
            if (w.ask_price != 0 && w.ask_volume != 0 && n_ask < BOOK_LEVELS) begin
                ask_px[n_ask] = w.ask_price;
                ask_vol[n_ask] = w.ask_volume;
                n_ask++;
            end
        end
        if (n_items < BOOK_LEVELS)
            n_items++;
        if (!w.last_level)
            return;
        if (n_bid > 0 && n_ask > 0) begin
            mid_x2_hold = 33'(bid_px[0]) + 33'(ask_px[0]);
            spread_hold = 33'(ask_px[0]) - 33'(bid_px[0]);
        end
        for (int i = 0; i < n_bid; i++) begin
            p2 = 34'(bid_px[i]) * 2;
            bd += 36'(bid_vol[i]);
            if (34'(mid_x2_hold) > p2)
                wb += inv_dist_weight(bid_vol[i], 34'(mid_x2_hold) - p2);
        end
        for (int i = 0; i < n_ask; i++) begin
            p2 = 34'(ask_px[i]) * 2;
            ad += 36'(ask_vol[i]);
            if (p2 > 34'(mid_x2_hold))
                wa += inv_dist_weight(ask_vol[i], p2 - 34'(mid_x2_hold));
        end
        r.time_out = w.snap_time;
        r.mid_price_x2 = mid_x2_hold;
        r.spread_out = spread_hold;
        r.bid_vol_sum = bd;
        r.ask_vol_sum = ad;
        r.volume_imbalance = q15_imbalance(86'(bd), 86'(ad));
        r.weighted_imbalance = q15_imbalance(wb, wa);
        r.bid_levels = 4'(n_bid);
        r.ask_levels = 4'(n_ask);
        stats_q.insert(stats_q.size(), r);
        n_bid = 0;
        n_ask = 0;
        n_items = 0;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk) begin
        level_word_t w;
        if (rst_n) begin
            if (in_valid && !in_stall)
                book_update(level_word_t'{bid_price, bid_volume, ask_price, ask_volume,
                                          snap_time, last_level});
            if (!in_valid || !in_stall) begin
                if (level_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    w = level_q.pop_front();
                    in_valid <= 1'b1;
                    bid_price <= w.bid_price;
                    bid_volume <= w.bid_volume;
                    ask_price <= w.ask_price;
                    ask_volume <= w.ask_volume;
                    snap_time <= w.snap_time;
                    last_level <= w.last_level;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        book_stats_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (stats_q.size() == 0) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word, time_out %0h", got.time_out);
                end else begin
                    e = stats_q.pop_front();
                    if (e !== got) begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %p\n          got %p", e, got);
                    end
                end
            end
            out_stall <= $urandom_range(99) < recv_idle;
        end
    end

    longint cycles = 0;
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TICK)
            tick_reg = val;
        else if (idx == REG_DEPTH_LEVELS)
            depth_reg = val[3:0];
    endtask

    task automatic settle();
        do @(posedge clk);
        while (level_q.size() != 0 || in_valid || stats_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_word(logic [31:0] bp, logic [31:0] bv, logic [31:0] ap,
                             logic [31:0] av, logic lst);
        level_q.insert(level_q.size(), level_word_t'{bp, bv, ap, av, $urandom, lst});
    endtask

    // a plausible book around a random centre; some fields dropped or wild
    task automatic push_book(int n);
        logic [31:0] centre, step, bp, bv, ap, av;
        centre = $urandom_range(9) == 0 ? $urandom : $urandom_range(100000, 1000);
        step = $urandom_range(3) == 0 ? $urandom_range(4000) : $urandom_range(20);
        for (int i = 0; i < n; i++) begin
            bp = centre - step * (i + 1) - $urandom_range(3);
            ap = centre + step * (i + 1) + $urandom_range(3);
            bv = $urandom_range(7) == 0 ? $urandom : $urandom_range(5000, 1);
            av = $urandom_range(7) == 0 ? $urandom : $urandom_range(5000, 1);
            if ($urandom_range(11) == 0) bp = 0;
            if ($urandom_range(11) == 0) bv = 0;
            if ($urandom_range(11) == 0) ap = 0;
            if ($urandom_range(11) == 0) av = 0;
            if ($urandom_range(19) == 0) bp = $urandom;
            if ($urandom_range(19) == 0) ap = $urandom;
            push_word(bp, bv, ap, av, i == n - 1);
        end
    endtask

    task automatic push_noise(int n);
        for (int i = 0; i < n; i++)
            push_word($urandom, $urandom, $urandom, $urandom, i == n - 1);
    endtask

    task automatic random_config();
        case ($urandom_range(5))
            0: write_reg(REG_TICK, 32'd0);
            1: write_reg(REG_TICK, 32'hFFFF_FFFF);
            2: write_reg(REG_TICK, $urandom);
            default: write_reg(REG_TICK, $urandom_range(50, 1));
        endcase
        write_reg(REG_DEPTH_LEVELS, $urandom_range(15));
    endtask

    task automatic random_regime(int words);
        int sent, n;
        sent = 0;
        while (sent < words) begin
            if (sent % 130 < 14) begin
                settle();
                random_config();
            end
            n = $urandom_range(5) == 0 ? $urandom_range(14, 1) : $urandom_range(6, 1);
            if ($urandom_range(7) == 0) push_noise(n);
            else push_book(n);
            sent += n;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default config, extremes, empty sides, crossed book
        push_word(32'd1000, 32'd10, 32'd1002, 32'd30, 1'b1);
        push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_word(32'd0, 32'd5, 32'd500, 32'd5, 1'b1);          // bid side empty
        push_word(32'd400, 32'd5, 32'd500, 32'd0, 1'b1);        // ask side empty
        push_word(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);            // both empty
        push_word(32'd900, 32'd7, 32'd800, 32'd7, 1'b1);        // crossed
        push_word(32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 1'b1);
        settle();
        write_reg(REG_DEPTH_LEVELS, 32'd15);                     // beyond the book size
        write_reg(REG_TICK, 32'hFFFF_FFFF);
        push_book(12);
        settle();
        write_reg(REG_TICK, 32'd0);                              // every weight zero
        write_reg(REG_DEPTH_LEVELS, 32'd0);                      // no word used
        push_book(3);
        settle();
        write_reg(REG_DEPTH_LEVELS, 32'd1);
        write_reg(REG_TICK, 32'd1);
        push_book(4);                                            // excess words
        settle();

        send_idle = 38; recv_idle = 51;
        random_regime(383);
        send_idle = 51; recv_idle = 38;
        random_regime(383);
        send_idle = 0; recv_idle = 0;
        random_regime(384);
        settle();

        if (!failed && stats_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
